// File: rtl/core/i2a_pkg.sv
// Shared types, constants and the digit-to-character function for the integer-to-ASCII block.
package i2a_pkg;

  // Field widths of the stream words.
  localparam int unsigned ValueW    = 32;
  localparam int unsigned RadixW    = 5;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned InDataW   = 40;

  // Decimal digits that a 32-bit magnitude can need.
  localparam int unsigned BcdDigits = 10;
  localparam int unsigned BcdW      = BcdDigits * DigitW;
  localparam int unsigned BcdIdxW   = $clog2(BcdDigits);
  localparam int unsigned HexDigits = ValueW / DigitW;

  // Supported number bases.
  localparam logic [RadixW-1:0] RadixDec = 5'd10;
  localparam logic [RadixW-1:0] RadixHex = 5'd16;

  // Character codes.
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChNone   = 8'h00;
  localparam logic [DigitW-1:0] DecBase = 4'd10;

  // Work word that travels down the conversion pipeline.
  typedef struct packed {
    logic              bad;
    logic              neg;
    logic              hex;
    logic [ValueW-1:0] mag;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } i2a_work_t;

  // Map one digit value to its upper-case ASCII character.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] ch;
    if (d < DecBase) begin
      ch = ChZero + {{(CharW-DigitW){1'b0}}, d};
    end else begin
      ch = ChUpperA + {{(CharW-DigitW){1'b0}}, d - DecBase};
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/integer_to_ascii_radix.sv
// Top level of the signed integer to decimal or hexadecimal ASCII converter.
//
// Each input word carries a signed 32-bit value and a radix; the block sends
// its text as one output word per character, most significant first: a '-'
// for negative values, then decimal or upper-case hex digits, with tlast on
// the final character. A radix other than 10 or 16 gives a single word with
// character 0 and tuser set. An input word passes an input register, four
// shift-and-add-3 stages of eight bits each and a digit-count stage before
// it reaches the character sequencer, whose output register holds the
// characters. A conversion gives 1 to 11 characters (at most 9 for
// hexadecimal); the sequencer takes the next word in the cycle of the final
// character, so output words follow without gaps and the output rate sets
// intake.
module integer_to_ascii_radix #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] value, [36:32] radix, [39:37] zero
  input  logic [i2a_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] char_out
  output logic [i2a_pkg::CharW-1:0]     m_axis_tdata,
  output logic                          m_axis_tlast,
  // [0] bad_radix
  output logic [0:0]                    m_axis_tuser
);
  import i2a_pkg::*;

  localparam int unsigned NumDabble = 4;
  localparam int unsigned DabSteps  = ValueW / NumDabble;
  localparam int unsigned IdxW      = $clog2(MAX_DIGITS);

  // Input register.
  logic              in_valid_q;
  i2a_work_t         in_work_q, in_work_d;
  logic              in_ready;

  // Conversion chain.
  logic      [NumDabble:0] dab_valid;
  logic      [NumDabble:0] dab_ready;
  i2a_work_t [NumDabble:0] dab_work;

  // Count stage.
  logic                              cnt_valid_q;
  logic                              cnt_ready;
  logic                              cnt_bad_q, cnt_neg_q;
  logic [MAX_DIGITS-1:0][DigitW-1:0] cnt_digits_q, cnt_digits_d;
  logic [IdxW-1:0]                   cnt_top_q, cnt_top_d;
  logic                              emit_ready;

  // Decode the radix and form the unsigned magnitude.
  always_comb begin
    logic [ValueW-1:0] value;
    logic [RadixW-1:0] radix;
    value         = s_axis_tdata[ValueW-1:0];
    radix         = s_axis_tdata[ValueW +: RadixW];
    in_work_d.bad = (radix != RadixDec) && (radix != RadixHex);
    in_work_d.hex = (radix == RadixHex);
    in_work_d.neg = value[ValueW-1];
    in_work_d.mag = value[ValueW-1] ? (ValueW'(0) - value) : value;
    in_work_d.bcd = '0;
    in_work_d.bin = in_work_d.mag;
  end

  assign in_ready      = !in_valid_q || dab_ready[0];
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_work_q <= in_work_d;
    end
  end

  assign dab_valid[0] = in_valid_q;
  assign dab_work[0]  = in_work_q;

  // Shift-and-add-3 stages.
  for (genvar g = 0; g < NumDabble; g++) begin : g_dabble
    i2a_dabble #(
      .Steps(DabSteps)
    ) u_dabble (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (dab_valid[g]),
      .in_ready_o (dab_ready[g]),
      .in_work_i  (dab_work[g]),
      .out_valid_o(dab_valid[g+1]),
      .out_ready_i(dab_ready[g+1]),
      .out_work_o (dab_work[g+1])
    );
  end

  assign cnt_ready            = !cnt_valid_q || emit_ready;
  assign dab_ready[NumDabble] = cnt_ready;

  // Pick the digits and find the most significant one to send.
  always_comb begin
    logic [BcdDigits-1:0][DigitW-1:0] all_digits;
    logic [BcdIdxW-1:0]               hi;
    i2a_work_t                        w;
    w  = dab_work[NumDabble];
    hi = '0;
    for (int unsigned i = 0; i < BcdDigits; i++) begin
      if (w.hex) begin
        all_digits[i] = (i < HexDigits) ? w.mag[(i % HexDigits)*DigitW +: DigitW] : '0;
      end else begin
        all_digits[i] = w.bcd[i*DigitW +: DigitW];
      end
    end
    for (int unsigned i = 0; i < BcdDigits; i++) begin
      if (all_digits[i] != '0) begin
        hi = BcdIdxW'(i);
      end
    end
    if (hi > BcdIdxW'(MAX_DIGITS - 1)) begin
      hi = BcdIdxW'(MAX_DIGITS - 1);
    end
    cnt_top_d = hi[IdxW-1:0];
    for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
      cnt_digits_d[i] = all_digits[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_valid_q <= 1'b0;
    end else if (cnt_ready) begin
      cnt_valid_q <= dab_valid[NumDabble];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_ready && dab_valid[NumDabble]) begin
      cnt_bad_q    <= dab_work[NumDabble].bad;
      cnt_neg_q    <= dab_work[NumDabble].neg;
      cnt_digits_q <= cnt_digits_d;
      cnt_top_q    <= cnt_top_d;
    end
  end

  // Character sequencer and output register.
  i2a_emitter #(
    .MaxDigits(MAX_DIGITS)
  ) u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (cnt_valid_q),
    .load_ready_o (emit_ready),
    .load_bad_i   (cnt_bad_q),
    .load_neg_i   (cnt_neg_q),
    .load_digits_i(cnt_digits_q),
    .load_top_i   (cnt_top_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_bad_o    (m_axis_tuser[0])
  );

endmodule

// File: rtl/core/i2a_dabble.sv
// One registered stage of the binary-to-BCD shift-and-add-3 converter.
module i2a_dabble #(
  parameter int unsigned Steps = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2a_pkg::i2a_work_t in_work_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2a_pkg::i2a_work_t out_work_o
);
  import i2a_pkg::*;

  logic      valid_q, valid_d;
  i2a_work_t work_q, work_d;

  // Stage advances when empty or when the next stage takes its word.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

  // A fixed number of shift-and-add-3 steps on the BCD accumulator.
  always_comb begin
    logic [BcdW+ValueW-1:0] acc;
    logic [BcdW-1:0]        bcd;
    work_d = in_work_i;
    acc    = {in_work_i.bcd, in_work_i.bin};
    for (int unsigned s = 0; s < Steps; s++) begin
      bcd = acc[BcdW+ValueW-1:ValueW];
      for (int unsigned j = 0; j < BcdDigits; j++) begin
        if (bcd[j*DigitW +: DigitW] >= 4'd5) begin
          bcd[j*DigitW +: DigitW] = bcd[j*DigitW +: DigitW] + 4'd3;
        end
      end
      acc = {bcd, acc[ValueW-1:0]} << 1;
    end
    work_d.bcd = acc[BcdW+ValueW-1:ValueW];
    work_d.bin = acc[ValueW-1:0];
  end

  assign valid_d = in_ready_o ? in_valid_i : valid_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

// File: rtl/core/i2a_emitter.sv
// Character sequencer that sends one conversion's characters, most significant first.
module i2a_emitter #(
  parameter int unsigned MaxDigits = 10,
  localparam int unsigned IdxW     = $clog2(MaxDigits)
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_valid_i,
  output logic                                       load_ready_o,
  input  logic                                       load_bad_i,
  input  logic                                       load_neg_i,
  input  logic [MaxDigits-1:0][i2a_pkg::DigitW-1:0] load_digits_i,
  input  logic [IdxW-1:0]                            load_top_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [i2a_pkg::CharW-1:0]                  out_char_o,
  output logic                                       out_last_o,
  output logic                                       out_bad_o
);
  import i2a_pkg::*;

  logic                              busy_q, busy_d;
  logic                              out_valid_q, out_valid_d;
  logic                              minus_q, minus_d;
  logic                              bad_q, bad_d;
  logic [IdxW-1:0]                   idx_q, idx_d;
  logic [MaxDigits-1:0][DigitW-1:0]  digits_q, digits_d;
  logic [CharW-1:0]                  char_q, char_d;
  logic                              last_q, last_d;
  logic                              obad_q, obad_d;
  logic                              out_free;
  logic                              finishing;
  logic                              emit;
  logic                              load;

  // Output register is free when empty or when its word is taken.
  assign out_free     = !out_valid_q || out_ready_i;
  assign finishing    = bad_q || (!minus_q && (idx_q == '0));
  assign load_ready_o = !busy_q || (out_free && finishing);
  assign emit         = busy_q && out_free;
  assign load         = load_valid_i && load_ready_o;

  // Next character and sequencer state.
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    minus_d     = minus_q;
    bad_d       = bad_q;
    idx_d       = idx_q;
    digits_d    = digits_q;
    char_d      = char_q;
    last_d      = last_q;
    obad_d      = obad_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (bad_q) begin
        char_d = ChNone;
        last_d = 1'b1;
        obad_d = 1'b1;
      end else if (minus_q) begin
        char_d  = ChMinus;
        last_d  = 1'b0;
        obad_d  = 1'b0;
        minus_d = 1'b0;
      end else begin
        char_d = digit_char(digits_q[idx_q]);
        last_d = (idx_q == '0);
        obad_d = 1'b0;
        if (idx_q != '0) begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      if (finishing) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d   = 1'b1;
      bad_d    = load_bad_i;
      minus_d  = load_neg_i && !load_bad_i;
      idx_d    = load_top_i;
      digits_d = load_digits_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_bad_o   = obad_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    minus_q  <= minus_d;
    bad_q    <= bad_d;
    idx_q    <= idx_d;
    digits_q <= digits_d;
    char_q   <= char_d;
    last_q   <= last_d;
    obad_q   <= obad_d;
  end

endmodule
